FILE: rtl/tmcw_pkg.sv
`default_nettype none
package tmcw_pkg;

   localparam int DEF_COLS = 80;
   localparam int DEF_ROWS = 25;

   localparam logic [7:0] NEWLINE_CODE   = 8'd10;
   localparam logic [7:0] BACKSPACE_CODE = 8'd8;
   localparam logic [7:0] BLANK_GLYPH    = 8'h20;
   localparam logic [7:0] RESET_ATTR     = 8'h07;

   typedef logic [15:0] cell_type;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_SCROLL,
      ST_CLEAR,
      ST_READ_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] char_code;
      logic [7:0] attr;
      logic [6:0] read_col;
      logic [4:0] read_row;
   } req_type;

   typedef struct packed {
      cell_type   cell_data;
      logic [6:0] cursor_col;
      logic [4:0] cursor_row;
      logic       did_scroll;
   } rsp_type;

endpackage
`default_nettype wire

FILE: rtl/tmcw_cell_ram.sv
`default_nettype none
module tmcw_cell_ram
   import tmcw_pkg::*;
#(
   parameter int DEPTH = DEF_COLS * DEF_ROWS,
   parameter int AW    = $clog2(DEF_COLS * DEF_ROWS)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire cell_type      wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output cell_type           rd_data
);

   cell_type mem [DEPTH];
   cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/text_mode_console_writer.sv
// Each accepted item goes through an execute state and a done state; an in-range read also
// waits in a read-wait state for the registered cell store output. Scroll or clear: a pass
// over all ROWS*COLS cells, one cell per cycle through the single write port of the cell
// store (copy pipelined with reads). One item at a time; a finished result waits in an
// output register.
// Reset: cursor homes, then a clearing pass blanks every cell, req_ready low.
`default_nettype none
module text_mode_console_writer
   import tmcw_pkg::*;
#(
   parameter int COLS = DEF_COLS,
   parameter int ROWS = DEF_ROWS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int NCELLS    = ROWS * COLS;
   localparam int AW        = $clog2(NCELLS);
   localparam int XW        = $clog2(COLS);
   localparam int YW        = $clog2(ROWS);
   localparam int COPY_END  = (ROWS - 1) * COLS;

   localparam logic [XW-1:0] LAST_X    = XW'(COLS - 1);
   localparam logic [YW-1:0] LAST_Y    = YW'(ROWS - 1);
   localparam logic [AW-1:0] LAST_CELL = AW'(NCELLS - 1);
   localparam logic [AW-1:0] COPY_LIM  = AW'(COPY_END);
   localparam logic [AW-1:0] ROW_STEP  = AW'(COLS);

   state_type     state_ff, state_in;
   req_type       req_ff, req_in;
   logic [XW-1:0] x_ff, x_in;
   logic [YW-1:0] y_ff, y_in;
   logic [AW-1:0] row_base_ff, row_base_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   cell_type      fill_word_ff, fill_word_in;
   cell_type      data_ff, data_in;
   logic          scrolled_ff, scrolled_in;
   logic          wr_en_ff, wr_en_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;
   logic          wr_copy_ff, wr_copy_in;
   cell_type      wr_word_ff, wr_word_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [AW-1:0] rd_addr;
   cell_type      rd_data;
   cell_type      wr_data;

   logic          req_fire;
   logic          rsp_free;
   logic          is_nl;
   logic          is_bs;
   logic          needs_row;
   logic          exec_scroll;
   logic          read_ok;
   logic [AW-1:0] read_lin;
   logic          copy_phase;

   assign req_fire    = req_valid && req_ready;
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign is_nl       = req_ff.char_code == NEWLINE_CODE;
   assign is_bs       = req_ff.char_code == BACKSPACE_CODE;
   assign needs_row   = (req_ff.op == OP_PUT) && (is_nl || (!is_bs && x_ff == LAST_X));
   assign exec_scroll = needs_row && (y_ff == LAST_Y);
   assign read_ok     = (32'(req_ff.read_col) < 32'(COLS)) && (32'(req_ff.read_row) < 32'(ROWS));
   assign read_lin    = AW'(32'(req_ff.read_row) * 32'(COLS) + 32'(req_ff.read_col));
   assign copy_phase  = cnt_ff < COPY_LIM;

   assign wr_data = wr_copy_ff ? rd_data : wr_word_ff;

   tmcw_cell_ram #(
      .DEPTH(NCELLS),
      .AW   (AW)
   ) u_cell_ram (
      .clock  (clock),
      .wr_en  (wr_en_ff),
      .wr_addr(wr_addr_ff),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (cnt_ff == LAST_CELL) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (req_ff.op)
               OP_PUT:   state_in = exec_scroll ? ST_SCROLL : ST_DONE;
               OP_CLEAR: state_in = ST_CLEAR;
               OP_READ:  state_in = read_ok ? ST_READ_WAIT : ST_DONE;
               default:  state_in = ST_DONE;
            endcase
         end
         ST_SCROLL, ST_CLEAR: begin
            if (cnt_ff == LAST_CELL) state_in = ST_DONE;
         end
         ST_READ_WAIT: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_comb begin
      req_in       = req_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      row_base_in  = row_base_ff;
      cnt_in       = cnt_ff;
      fill_word_in = fill_word_ff;
      data_in      = data_ff;
      scrolled_in  = scrolled_ff;
      wr_en_in     = 1'b0;
      wr_addr_in   = wr_addr_ff;
      wr_copy_in   = 1'b0;
      wr_word_in   = wr_word_ff;
      rd_addr      = '0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;

      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            wr_en_in   = 1'b1;
            wr_addr_in = cnt_ff;
            wr_word_in = fill_word_ff;
            cnt_in     = cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) req_in = req_data;
         end
         ST_EXEC: begin
            data_in      = '0;
            scrolled_in  = 1'b0;
            cnt_in       = '0;
            fill_word_in = {req_ff.attr, BLANK_GLYPH};
            case (req_ff.op)
               OP_PUT: begin
                  if (is_bs) begin
                     if (x_ff != '0) begin
                        x_in       = x_ff - 1'b1;
                        wr_en_in   = 1'b1;
                        wr_addr_in = row_base_ff + AW'(x_ff - 1'b1);
                        wr_word_in = {req_ff.attr, BLANK_GLYPH};
                     end
                  end else if (!is_nl) begin
                     x_in       = x_ff + 1'b1;
                     wr_en_in   = 1'b1;
                     wr_addr_in = row_base_ff + AW'(x_ff);
                     wr_word_in = {req_ff.attr, req_ff.char_code};
                  end
                  if (needs_row) begin
                     x_in = '0;
                     if (y_ff == LAST_Y) begin
                        scrolled_in = 1'b1;
                     end else begin
                        y_in        = y_ff + 1'b1;
                        row_base_in = row_base_ff + ROW_STEP;
                     end
                  end
               end
               OP_CLEAR: begin
                  x_in        = '0;
                  y_in        = '0;
                  row_base_in = '0;
               end
               OP_READ: begin
                  if (read_ok) rd_addr = read_lin;
               end
               default: ;
            endcase
         end
         ST_SCROLL: begin
            // read one row below, write back next cycle; bottom row gets blanks
            wr_en_in   = 1'b1;
            wr_addr_in = cnt_ff;
            wr_copy_in = copy_phase;
            wr_word_in = fill_word_ff;
            if (copy_phase) rd_addr = cnt_ff + ROW_STEP;
            cnt_in     = cnt_ff + 1'b1;
         end
         ST_READ_WAIT: data_in = rd_data;
         ST_DONE: begin
            if (rsp_free) begin
               rsp_in.cell_data  = data_ff;
               rsp_in.cursor_col = 7'(x_ff);
               rsp_in.cursor_row = 5'(y_ff);
               rsp_in.did_scroll = scrolled_ff;
               rsp_valid_in      = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         x_ff         <= '0;
         y_ff         <= '0;
         row_base_ff  <= '0;
         cnt_ff       <= '0;
         fill_word_ff <= {RESET_ATTR, BLANK_GLYPH};
         wr_en_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         row_base_ff  <= row_base_in;
         cnt_ff       <= cnt_in;
         fill_word_ff <= fill_word_in;
         wr_en_ff     <= wr_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      data_ff     <= data_in;
      scrolled_ff <= scrolled_in;
      wr_addr_ff  <= wr_addr_in;
      wr_copy_ff  <= wr_copy_in;
      wr_word_ff  <= wr_word_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_cursor_in_grid: assert property (@(posedge clock) disable iff (reset)
      (x_ff <= LAST_X) && (y_ff <= LAST_Y))
      else $error("cursor left the grid");

   a_row_base_tracks_row: assert property (@(posedge clock) disable iff (reset)
      32'(row_base_ff) == 32'(y_ff) * 32'(COLS))
      else $error("row base out of step with cursor row");

   a_accept_starts_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_EXEC))
      else $error("accepted beat did not start execution");

   a_scroll_flagged: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCROLL) |-> (scrolled_ff && (y_ff == LAST_Y) && (x_ff == '0)))
      else $error("scroll pass without scroll flag or bottom-row cursor");

   a_scroll_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.did_scroll) |->
         ((rsp_ff.cursor_col == 7'd0) && (rsp_ff.cursor_row == 5'(ROWS - 1))))
      else $error("scroll reported with cursor off the bottom row start");
`endif

endmodule
`default_nettype wire

FILE: dv/text_mode_console_writer_test.sv
`timescale 1ns / 100ps
`default_nettype none
module text_mode_console_writer_test;
   import tmcw_pkg::*;

   localparam int COLS = DEF_COLS;
   localparam int ROWS = DEF_ROWS;
   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam int RANDOM_ITEMS = 300;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } console_step_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // shadow of the console
   logic [15:0] screen [ROWS*COLS];
   int          cur_col;
   int          cur_row;

   rsp_type expected_replies [$];
   int      mismatches = 0;
   int      items_sent = 0;
   bit      calm = 1'b0;

   text_mode_console_writer #(
      .COLS(COLS),
      .ROWS(ROWS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #4 clock = ~clock;

   function automatic console_step_type make_step(op_type op, int ch, int attr, int col,
                                                  int row, bit typed, int cell_word,
                                                  int ccol, int crow);
      console_step_type s;
      s.req.op        = op;
      s.req.char_code = 8'(ch);
      s.req.attr      = 8'(attr);
      s.req.read_col  = 7'(col);
      s.req.read_row  = 5'(row);
      s.typed         = typed;
      s.want.cell_data  = 16'(cell_word);
      s.want.cursor_col = 7'(ccol);
      s.want.cursor_row = 5'(crow);
      s.want.did_scroll = 1'b0;
      return s;
   endfunction

   task automatic blank_screen(input logic [7:0] attr);
      for (int i = 0; i < ROWS*COLS; i++) screen[i] = {attr, BLANK_GLYPH};
   endtask

   // cursor to column 0 of the next row, scrolling at the bottom
   task automatic line_feed(input logic [7:0] attr, output logic scrolled);
      cur_col  = 0;
      scrolled = 1'b0;
      if (cur_row + 1 >= ROWS) begin
         for (int i = 0; i < (ROWS-1)*COLS; i++) screen[i] = screen[i+COLS];
         for (int x = 0; x < COLS; x++) screen[(ROWS-1)*COLS + x] = {attr, BLANK_GLYPH};
         cur_row  = ROWS - 1;
         scrolled = 1'b1;
      end else begin
         cur_row++;
      end
   endtask

   task automatic predict_console(input req_type r, output rsp_type o);
      logic scrolled;
      logic [15:0] cell_word;
      scrolled  = 1'b0;
      cell_word = '0;
      case (r.op)
         OP_PUT: begin
            if (r.char_code == NEWLINE_CODE) begin
               line_feed(r.attr, scrolled);
            end else if (r.char_code == BACKSPACE_CODE) begin
               if (cur_col > 0) begin
                  cur_col--;
                  screen[cur_row*COLS + cur_col] = {r.attr, BLANK_GLYPH};
               end
            end else begin
               screen[cur_row*COLS + cur_col] = {r.attr, r.char_code};
               cur_col++;
               if (cur_col >= COLS) line_feed(r.attr, scrolled);
            end
         end
         OP_CLEAR: begin
            blank_screen(r.attr);
            cur_col = 0;
            cur_row = 0;
         end
         OP_READ: begin
            if (r.read_col < COLS && r.read_row < ROWS)
               cell_word = screen[int'(r.read_row)*COLS + int'(r.read_col)];
         end
         default: ;
      endcase
      o.cell_data  = cell_word;
      o.cursor_col = 7'(cur_col);
      o.cursor_row = 5'(cur_row);
      o.did_scroll = scrolled;
   endtask

   // enter and leave at a falling edge
   task automatic send_req(input req_type r, input bit typed, input rsp_type want);
      rsp_type predicted;
      while (!calm && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_console(r, predicted);
      expected_replies.push_back(typed ? want : predicted);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_op(input op_type op, input logic [7:0] ch, input logic [6:0] col,
                          input logic [4:0] row);
      req_type r;
      r.op        = op;
      r.char_code = ch;
      r.attr      = 8'($urandom_range(255));
      r.read_col  = col;
      r.read_row  = row;
      send_req(r, 1'b0, '0);
   endtask

   task automatic send_text_char();
      logic [7:0] ch;
      if ($urandom_range(5) == 0) ch = BACKSPACE_CODE;
      else if ($urandom_range(7) == 0) ch = 8'($urandom_range(255));
      else ch = 8'($urandom_range(32, 126));
      send_op(OP_PUT, ch, 7'($urandom_range(127)), 5'($urandom_range(31)));
   endtask

   // hold the sender until every reply is in
   task automatic drain_replies();
      req_valid <= 1'b0;
      wait (expected_replies.size() == 0);
      @(negedge clock);
   endtask

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch on %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 17);
   end

   always @(posedge clock) begin : check_replies
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_replies.size() == 0) begin
            report_mismatch("unexpected beat", 32'(rsp_data), 0);
         end else begin
            want = expected_replies.pop_front();
            if (rsp_data.cell_data !== want.cell_data)
               report_mismatch("cell_data", 32'(rsp_data.cell_data), 32'(want.cell_data));
            if (rsp_data.cursor_col !== want.cursor_col)
               report_mismatch("cursor_col", 32'(rsp_data.cursor_col),
                               32'(want.cursor_col));
            if (rsp_data.cursor_row !== want.cursor_row)
               report_mismatch("cursor_row", 32'(rsp_data.cursor_row),
                               32'(want.cursor_row));
            if (rsp_data.did_scroll !== want.did_scroll)
               report_mismatch("did_scroll", 32'(rsp_data.did_scroll),
                               32'(want.did_scroll));
         end
      end
   end

   initial begin
      #(40_000_000);
      $display("timeout with %0d beats outstanding", expected_replies.size());
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      console_step_type steps [$];
      int               kind;
      int               n;
      op_type           spare;

      spare = op_type'(OP_SPARE);
      blank_screen(RESET_ATTR);
      cur_col = 0;
      cur_row = 0;

      steps = '{
         make_step(OP_READ,  0, 8'h00, 0, 0, 1, 16'h0720, 0, 0),
         make_step(OP_READ,  0, 8'h00, COLS-1, ROWS-1, 1, 16'h0720, 0, 0),
         make_step(OP_READ,  8'hFF, 8'hFF, 127, 31, 1, 0, 0, 0),
         make_step(OP_READ,  0, 8'h00, COLS, 0, 1, 0, 0, 0),
         make_step(OP_READ,  0, 8'h00, 0, ROWS, 1, 0, 0, 0),
         make_step(OP_PUT,   BACKSPACE_CODE, 8'hFF, 0, 0, 1, 0, 0, 0),
         make_step(OP_READ,  0, 8'h00, 0, 0, 1, 16'h0720, 0, 0),
         make_step(spare,    8'hFF, 8'hFF, 127, 31, 1, 0, 0, 0),
         make_step(OP_PUT,   8'h41, 8'h1F, 0, 0, 0, 0, 0, 0),
         make_step(OP_PUT,   8'hFF, 8'h00, 127, 31, 0, 0, 0, 0),
         make_step(OP_PUT,   8'h00, 8'hF0, 0, 0, 0, 0, 0, 0),
         make_step(OP_PUT,   8'd13, 8'h07, 0, 0, 0, 0, 0, 0),
         make_step(OP_READ,  0, 8'h00, 0, 0, 0, 0, 0, 0),
         make_step(OP_READ,  0, 8'h00, 1, 0, 0, 0, 0, 0),
         make_step(OP_READ,  0, 8'h00, 2, 0, 0, 0, 0, 0),
         make_step(OP_READ,  0, 8'h00, 3, 0, 0, 0, 0, 0),
         make_step(OP_PUT,   BACKSPACE_CODE, 8'h2E, 0, 0, 0, 0, 0, 0),
         make_step(OP_READ,  0, 8'h00, 3, 0, 0, 0, 0, 0),
         make_step(OP_PUT,   NEWLINE_CODE, 8'h07, 0, 0, 0, 0, 0, 0),
         make_step(OP_CLEAR, 0, 8'hFF, 0, 0, 1, 0, 0, 0),
         make_step(OP_READ,  0, 8'h00, COLS-1, ROWS-1, 1, 16'hFF20, 0, 0),
         make_step(OP_CLEAR, 0, 8'h07, 0, 0, 1, 0, 0, 0)
      };

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (steps[i]) send_req(steps[i].req, steps[i].typed, steps[i].want);
      drain_replies();

      // text lines, blank-line bursts and reads around the cursor, with some noise
      while (items_sent < steps.size() + RANDOM_ITEMS) begin
         calm = (items_sent >= 140 && items_sent < 220);
         kind = $urandom_range(19);
         if (kind <= 7) begin
            n = $urandom_range(5);
            repeat (n) send_text_char();
            send_op(OP_PUT, NEWLINE_CODE, '0, '0);
         end else if (kind == 8) begin
            n = $urandom_range(COLS - 5, COLS + 5);
            repeat (n) send_op(OP_PUT, 8'($urandom_range(32, 126)), '0, '0);
            send_op(OP_PUT, NEWLINE_CODE, '0, '0);
         end else if (kind <= 11) begin
            n = $urandom_range(1, 10);
            repeat (n) send_op(OP_PUT, NEWLINE_CODE, 7'($urandom_range(127)),
                               5'($urandom_range(31)));
         end else if (kind <= 15) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
               case ($urandom_range(2))
                  0: send_op(OP_READ, 8'($urandom_range(255)), 7'($urandom_range(COLS-1)),
                             5'(cur_row));
                  1: send_op(OP_READ, 8'($urandom_range(255)), 7'($urandom_range(COLS-1)),
                             5'($urandom_range(ROWS-1)));
                  default: send_op(OP_READ, 8'($urandom_range(255)), 7'($urandom_range(127)),
                                   5'($urandom_range(31)));
               endcase
            end
         end else if (kind == 16 && $urandom_range(2) == 0) begin
            send_op(OP_CLEAR, 8'($urandom_range(255)), 7'($urandom_range(127)),
                    5'($urandom_range(31)));
         end else begin
            send_req(req_type'($urandom), 1'b0, '0);
         end
         if ($urandom_range(15) == 0) drain_replies();
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      wait (expected_replies.size() == 0);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
